// ----- src/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the serial LCD line terminal
// Command codes, queue entry layout and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

  localparam int ROW_WIDTH = 16;
  localparam int COL_W     = $clog2(ROW_WIDTH);
  localparam int Q_AW      = 1;
  localparam int Q_DEPTH   = 1 << Q_AW;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_BLOCK = 8'hff;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    OP_POS   = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_HOME  = 2'd3
  } lcd_op_t;

  typedef enum logic [1:0] {
    K_ECHO,        // write char, no store
    K_ECHO_STORE,  // write char and keep it in the line store
    K_NEWLINE      // second-row return: clear and replay
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       ch;       // byte for the first write
    logic [COL_W-1:0] idx;      // store index, or replay length
    logic [COL_W-1:0] pos_col;  // cursor column after this char
    logic             pos_row;  // cursor row after this char
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO,
    ST_HOME,
    ST_CLEAR,
    ST_REPLAY,
    ST_POS1,
    ST_BLOCK,
    ST_POS2
  } bk_state_t;

  // low 4 bits of a column for the LCD address field
  function automatic logic [3:0] to_lcd_col(input logic [COL_W-1:0] col);
    logic [COL_W+3:0] ext;
    ext = {4'b0000, col};
    return ext[3:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/serial_lcd_line_terminal_unit.sv -----
// ----------------------------------------------------------------------------
// serial_lcd_line_terminal_unit: serial byte to LCD command terminal
// Turns received bytes into command runs for a two-row character LCD.
// ----------------------------------------------------------------------------
// Each byte pushed in produces a run of LCD commands popped out one per
// transfer; the last command of a run has run_last set. A classifier
// accepts a byte per cycle, while the queue is not full, into a two-entry
// queue; a single sequencer then issues one command per cycle while the
// output register has room. An ordinary byte or a first-row return loads
// one entry and then issues four commands; a return in second-row mode
// issues 6 + n commands, where n is the number of stored bytes replayed
// (at most 15 for a 16-column row). Throughput is bounded by the sequencer and by how fast results are popped.
`default_nettype none

module serial_lcd_line_terminal_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_rx_char,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_lcd_op,
  output logic [3:0]       out_lcd_col,
  output logic             out_lcd_row,
  output logic [7:0]       out_lcd_data,
  output logic             out_run_last
);

  logic             q_push, q_pop, q_full, q_empty;
  slt_pkg::entry_t  wr_entry, rd_entry;

  assign in_full = q_full;

  slt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_char (in_rx_char),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (wr_entry)
  );

  slt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .rd_entry (rd_entry)
  );

  slt_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_entry      (rd_entry),
    .q_pop        (q_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_lcd_op   (out_lcd_op),
    .out_lcd_col  (out_lcd_col),
    .out_lcd_row  (out_lcd_row),
    .out_lcd_data (out_lcd_data),
    .out_run_last (out_run_last)
  );

endmodule

`default_nettype wire

// ----- src/slt_front.sv -----
// ----------------------------------------------------------------------------
// slt_front: character classifier
// Tracks row mode and cursor column, turns each byte into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire logic [7:0]    in_rx_char,
  input  wire logic          q_full,
  output logic               q_push,
  output slt_pkg::entry_t    q_entry
);

  logic                      mode_r, mode_nxt;
  logic [slt_pkg::COL_W-1:0] col_r, col_nxt;
  logic [slt_pkg::COL_W-1:0] col_adv;
  logic [slt_pkg::COL_W:0]   col_inc;

  assign q_push  = in_push && !q_full;
  assign col_inc = {1'b0, col_r} + 1'b1;
  assign col_adv = (col_inc == (slt_pkg::COL_W+1)'(slt_pkg::ROW_WIDTH)) ?
                   '0 : col_inc[slt_pkg::COL_W-1:0];

  always_comb begin
    mode_nxt      = mode_r;
    col_nxt       = col_adv;
    q_entry.kind  = slt_pkg::K_ECHO;
    q_entry.ch    = in_rx_char;
    q_entry.idx   = col_r;
    if (!mode_r) begin
      if (in_rx_char == slt_pkg::CHAR_CR) begin
        q_entry.ch = slt_pkg::CHAR_SPACE;
        col_nxt    = '0;
        mode_nxt   = 1'b1;
      end
    end else if (in_rx_char == slt_pkg::CHAR_CR) begin
      q_entry.kind = slt_pkg::K_NEWLINE;
      q_entry.ch   = slt_pkg::CHAR_SPACE;
      col_nxt      = '0;
    end else begin
      q_entry.kind = slt_pkg::K_ECHO_STORE;
    end
    q_entry.pos_col = col_nxt;
    q_entry.pos_row = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      col_r  <= '0;
    end else if (q_push) begin
      mode_r <= mode_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/slt_queue.sv -----
// ----------------------------------------------------------------------------
// slt_queue: short entry queue
// Decouples the classifier from the command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire slt_pkg::entry_t  wr_entry,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output slt_pkg::entry_t       rd_entry
);

  slt_pkg::entry_t              ent_r [slt_pkg::Q_DEPTH];
  logic [slt_pkg::Q_AW-1:0]     wp_r, rp_r;
  logic [slt_pkg::Q_AW:0]       cnt_r;
  logic                         do_push, do_pop;

  assign full     = (cnt_r == (slt_pkg::Q_AW+1)'(slt_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/slt_back.sv -----
// ----------------------------------------------------------------------------
// slt_back: LCD command sequencer
// Expands queue entries into LCD commands, owns the line store and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire slt_pkg::entry_t  q_entry,
  output logic                  q_pop,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output logic [1:0]            out_lcd_op,
  output logic [3:0]            out_lcd_col,
  output logic                  out_lcd_row,
  output logic [7:0]            out_lcd_data,
  output logic                  out_run_last
);

  slt_pkg::bk_state_t        state_r, state_nxt;
  slt_pkg::entry_t           ent_r;
  logic [slt_pkg::COL_W-1:0] idx_r, idx_nxt;
  logic [7:0]                mem [slt_pkg::ROW_WIDTH];
  logic [7:0]                rd_data_r;
  logic                      st_wr;

  logic                      emit, space;
  slt_pkg::lcd_op_t          cmd_op;
  logic [3:0]                cmd_col;
  logic                      cmd_row;
  logic [7:0]                cmd_data;
  logic                      cmd_last;

  logic                      out_vld_r;
  slt_pkg::lcd_op_t          out_op_r;
  logic [3:0]                out_col_r;
  logic                      out_row_r;
  logic [7:0]                out_data_r;
  logic                      out_last_r;

  assign space = !out_vld_r || out_pop;

  // command outputs per state
  always_comb begin
    emit     = 1'b0;
    q_pop    = 1'b0;
    st_wr    = 1'b0;
    cmd_op   = slt_pkg::OP_POS;
    cmd_col  = '0;
    cmd_row  = 1'b0;
    cmd_data = '0;
    cmd_last = 1'b0;
    unique case (state_r)
      slt_pkg::ST_IDLE: begin
        q_pop = !q_empty;
      end
      slt_pkg::ST_ECHO: begin
        emit     = 1'b1;
        cmd_op   = slt_pkg::OP_DATA;
        cmd_data = ent_r.ch;
        st_wr    = (ent_r.kind == slt_pkg::K_ECHO_STORE);
      end
      slt_pkg::ST_HOME: begin
        emit   = 1'b1;
        cmd_op = slt_pkg::OP_HOME;
      end
      slt_pkg::ST_CLEAR: begin
        emit   = 1'b1;
        cmd_op = slt_pkg::OP_CLEAR;
      end
      slt_pkg::ST_REPLAY: begin
        // stop at the line length or at a stored zero byte
        emit     = (idx_r != ent_r.idx) && (rd_data_r != 8'h00);
        cmd_op   = slt_pkg::OP_DATA;
        cmd_data = emit ? rd_data_r : 8'h00;
      end
      slt_pkg::ST_POS1: begin
        emit    = 1'b1;
        cmd_col = slt_pkg::to_lcd_col(ent_r.pos_col);
        cmd_row = ent_r.pos_row;
      end
      slt_pkg::ST_BLOCK: begin
        emit     = 1'b1;
        cmd_op   = slt_pkg::OP_DATA;
        cmd_data = slt_pkg::CHAR_BLOCK;
      end
      slt_pkg::ST_POS2: begin
        emit     = 1'b1;
        cmd_col  = slt_pkg::to_lcd_col(ent_r.pos_col);
        cmd_row  = ent_r.pos_row;
        cmd_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slt_pkg::ST_IDLE:   if (!q_empty) state_nxt = slt_pkg::ST_ECHO;
      slt_pkg::ST_ECHO: begin
        if (space) begin
          state_nxt = (ent_r.kind == slt_pkg::K_NEWLINE) ? slt_pkg::ST_HOME :
                                                           slt_pkg::ST_POS1;
        end
      end
      slt_pkg::ST_HOME:   if (space) state_nxt = slt_pkg::ST_CLEAR;
      slt_pkg::ST_CLEAR:  if (space) state_nxt = slt_pkg::ST_REPLAY;
      slt_pkg::ST_REPLAY: if (!emit) state_nxt = slt_pkg::ST_POS1;
      slt_pkg::ST_POS1:   if (space) state_nxt = slt_pkg::ST_BLOCK;
      slt_pkg::ST_BLOCK:  if (space) state_nxt = slt_pkg::ST_POS2;
      slt_pkg::ST_POS2:   if (space) state_nxt = slt_pkg::ST_IDLE;
      default:            state_nxt = slt_pkg::ST_IDLE;
    endcase
  end

  // replay index; the store is read at the next index so data lines up
  always_comb begin
    if (state_r == slt_pkg::ST_REPLAY) begin
      idx_nxt = (emit && space) ? idx_r + 1'b1 : idx_r;
    end else begin
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_wr) begin
      mem[ent_r.idx] <= ent_r.ch;
    end
    rd_data_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_entry;
    end
    idx_r <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (space) begin
      out_vld_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (space && emit) begin
      out_op_r   <= cmd_op;
      out_col_r  <= cmd_col;
      out_row_r  <= cmd_row;
      out_data_r <= cmd_data;
      out_last_r <= cmd_last;
    end
  end

  assign out_empty    = !out_vld_r;
  assign out_lcd_op   = out_op_r;
  assign out_lcd_col  = out_col_r;
  assign out_lcd_row  = out_row_r;
  assign out_lcd_data = out_data_r;
  assign out_run_last = out_last_r;

endmodule

`default_nettype wire

// ----- tb/slt_lcd_run_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slt_lcd_run_checker: LCD command run predictor and scoreboard
// Watches both queue channels of the line terminal, builds the expected LCD
// command run for every character transfer and compares each popped command.
// ----------------------------------------------------------------------------

module slt_lcd_run_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic [7:0] in_rx_char,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [1:0] out_lcd_op,
  input  logic [3:0] out_lcd_col,
  input  logic       out_lcd_row,
  input  logic [7:0] out_lcd_data,
  input  logic       out_run_last,
  output int         err_count,
  output int         pending_cmds,
  output int         cmds_checked
);

  typedef struct packed {
    slt_pkg::lcd_op_t op;
    logic [3:0]       col;
    logic             row;
    logic [7:0]       data;
    logic             last;
  } lcd_cmd_t;

  lcd_cmd_t   lcd_cmd_q[$];
  logic       second_row;
  int         cur_col;
  logic [7:0] line_buf [slt_pkg::ROW_WIDTH];

  initial begin
    err_count    = 0;
    pending_cmds = 0;
    cmds_checked = 0;
  end

  task automatic queue_cmd(input slt_pkg::lcd_op_t op, input logic [3:0] col,
                           input logic row, input logic [7:0] data, input logic last);
    lcd_cmd_t cmd;
    cmd.op   = op;
    cmd.col  = col;
    cmd.row  = row;
    cmd.data = data;
    cmd.last = last;
    lcd_cmd_q.push_back(cmd);
  endtask

  task automatic advance_col();
    cur_col = (cur_col >= slt_pkg::ROW_WIDTH - 1) ? 0 : cur_col + 1;
  endtask

  // expected command run for one received character
  task automatic predict_lcd_run(input logic [7:0] ch);
    int   replay_len;
    int   idx;
    logic stop;
    if (!second_row) begin
      if (ch == slt_pkg::CHAR_CR) begin
        queue_cmd(slt_pkg::OP_DATA, 4'd0, 1'b0, slt_pkg::CHAR_SPACE, 1'b0);
        cur_col    = 0;
        second_row = 1'b1;
      end else begin
        queue_cmd(slt_pkg::OP_DATA, 4'd0, 1'b0, ch, 1'b0);
        advance_col();
      end
    end else if (ch == slt_pkg::CHAR_CR) begin
      replay_len = cur_col;
      queue_cmd(slt_pkg::OP_DATA, 4'd0, 1'b0, slt_pkg::CHAR_SPACE, 1'b0);
      queue_cmd(slt_pkg::OP_HOME, 4'd0, 1'b0, 8'h00, 1'b0);
      queue_cmd(slt_pkg::OP_CLEAR, 4'd0, 1'b0, 8'h00, 1'b0);
      // replay stops early at a stored zero byte
      idx  = 0;
      stop = 1'b0;
      while (idx < replay_len && !stop) begin
        if (line_buf[idx] == 8'h00) begin
          stop = 1'b1;
        end else begin
          queue_cmd(slt_pkg::OP_DATA, 4'd0, 1'b0, line_buf[idx], 1'b0);
          idx++;
        end
      end
      cur_col = 0;
    end else begin
      queue_cmd(slt_pkg::OP_DATA, 4'd0, 1'b0, ch, 1'b0);
      line_buf[cur_col] = ch;
      advance_col();
    end
    // block cursor at the new position, address left on it
    queue_cmd(slt_pkg::OP_POS, cur_col[3:0], second_row, 8'h00, 1'b0);
    queue_cmd(slt_pkg::OP_DATA, 4'd0, 1'b0, slt_pkg::CHAR_BLOCK, 1'b0);
    queue_cmd(slt_pkg::OP_POS, cur_col[3:0], second_row, 8'h00, 1'b1);
  endtask

  task automatic compare_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      err_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, expv, actv);
    end
  endtask

  task automatic check_lcd_cmd();
    lcd_cmd_t want;
    if (lcd_cmd_q.size() == 0) begin
      err_count++;
      $display("%0t: unexpected command, expected none, actual op %0d col %0d row %0d %s",
               $time, out_lcd_op, out_lcd_col, out_lcd_row,
               $sformatf("data 0x%0h", out_lcd_data));
    end else begin
      want = lcd_cmd_q.pop_front();
      compare_field("lcd_op", want.op, out_lcd_op);
      compare_field("lcd_col", want.col, out_lcd_col);
      compare_field("lcd_row", want.row, out_lcd_row);
      compare_field("lcd_data", want.data, out_lcd_data);
      compare_field("run_last", want.last, out_run_last);
      cmds_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      second_row = 1'b0;
      cur_col    = 0;
      for (int i = 0; i < slt_pkg::ROW_WIDTH; i++) line_buf[i] = 8'h00;
      lcd_cmd_q.delete();
    end else begin
      if (out_pop && !out_empty) check_lcd_cmd();
      if (in_push && !in_full) predict_lcd_run(in_rx_char);
    end
    pending_cmds <= lcd_cmd_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the serial LCD line terminal
// Drives received characters in bursts, pops LCD commands with a stall
// pattern, and reports the verdict from the run checker.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 85;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_push    = 1'b0;
  logic [7:0] in_rx_char = 8'h00;
  logic       out_pop    = 1'b0;
  logic       in_full;
  logic       out_empty;
  logic [1:0] out_lcd_op;
  logic [3:0] out_lcd_col;
  logic       out_lcd_row;
  logic [7:0] out_lcd_data;
  logic       out_run_last;

  int err_count;
  int pending_cmds;
  int cmds_checked;
  int cycle_count  = 0;
  int chars_sent   = 0;
  int returns_sent = 0;
  int lines_sent   = 0;
  int burst_left   = 0;
  int pop_phase    = 0;
  int pop_mode     = 0;

  // first row filled past its width, both kinds of return, replay cut by a zero byte
  logic [7:0] directed_chars [23] = '{
    8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'hfe, 8'h20, 8'h41,
    8'h55, 8'haa, 8'h0c, 8'h0e, 8'h02, 8'h40, 8'h10, 8'h08,
    8'h5a, slt_pkg::CHAR_CR, slt_pkg::CHAR_CR, 8'h48, 8'h00, 8'h49, slt_pkg::CHAR_CR
  };

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  serial_lcd_line_terminal_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_rx_char   (in_rx_char),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_lcd_op   (out_lcd_op),
    .out_lcd_col  (out_lcd_col),
    .out_lcd_row  (out_lcd_row),
    .out_lcd_data (out_lcd_data),
    .out_run_last (out_run_last)
  );

  slt_lcd_run_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_rx_char   (in_rx_char),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_lcd_op   (out_lcd_op),
    .out_lcd_col  (out_lcd_col),
    .out_lcd_row  (out_lcd_row),
    .out_lcd_data (out_lcd_data),
    .out_run_last (out_run_last),
    .err_count    (err_count),
    .pending_cmds (pending_cmds),
    .cmds_checked (cmds_checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d commands outstanding",
               $time, cycle_count, pending_cmds);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: switches between full rate, coin flip and long stalls, each phase picked at random
  always @(posedge clk) begin
    if (pop_phase == 0) begin
      pop_mode  <= $urandom_range(0, 2);
      pop_phase <= 63;
    end else begin
      pop_phase <= pop_phase - 1;
    end
    case (pop_mode)
      0:       out_pop <= 1'b1;
      1:       out_pop <= ($urandom_range(0, 1) == 1);
      default: out_pop <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // one transfer; the sender pauses between bursts of random length
  task automatic send_char(input logic [7:0] ch);
    if (burst_left == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    in_push    <= 1'b1;
    in_rx_char <= ch;
    do @(posedge clk); while (in_full);
    burst_left--;
    chars_sent++;
    if (ch == slt_pkg::CHAR_CR) returns_sent++;
  endtask

  function automatic logic [7:0] line_char();
    if ($urandom_range(0, 11) == 0) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int rand_items;
    int line_len;
    int pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_chars[i]) send_char(directed_chars[i]);

    // random lines in second-row mode, some past the row width, some full length
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      line_len = $urandom_range(slt_pkg::ROW_WIDTH, slt_pkg::ROW_WIDTH + 6);
      else if (pick <= 2) line_len = slt_pkg::ROW_WIDTH - 1;
      else                line_len = $urandom_range(0, slt_pkg::ROW_WIDTH - 2);
      for (int i = 0; i < line_len; i++) send_char(line_char());
      send_char(slt_pkg::CHAR_CR);
      rand_items += line_len + 1;
      lines_sent++;
    end
    in_push <= 1'b0;
    // let the count include the run of the last transfer
    @(posedge clk);

    while (pending_cmds != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered: %0d characters pushed (%0d returns, %0d random lines)",
             chars_sent, returns_sent, lines_sent);
    $display("Covered: %0d LCD commands checked, first-row wrap and zero-byte replay stop",
             cmds_checked);
    if (pending_cmds != 0)
      $display("%0t: %0d expected commands never arrived", $time, pending_cmds);
    if (err_count == 0 && pending_cmds == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- serial_lcd_line_terminal_unit.f -----
src/slt_pkg.sv
src/slt_front.sv
src/slt_queue.sv
src/slt_back.sv
src/serial_lcd_line_terminal_unit.sv
tb/slt_lcd_run_checker.sv
tb/testbench.sv
